// File: rtl/core/swap_slot_table_unit_assert.svh
// Assertion macros for the swap slot table unit.
// Used by swap_slot_table_unit.sv; expects clk and rst_n in scope.
`ifndef SWAP_SLOT_TABLE_UNIT_ASSERT_SVH
`define SWAP_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sst_pkg.sv
// Shared types and codes of the swap slot table unit.
// No dependencies; used by swap_slot_table_unit.sv.
`default_nettype none

package sst_pkg;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int PAGE_W   = 20;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;
    localparam int SECTOR_W = 11;
    localparam int COUNT_W  = 9;

    // Reset value of the slot count register
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_STORE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PAGE_W-1:0]   page_number;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [SECTOR_W-1:0] first_sector;
    } out_t;

    // One table entry: taken flag over the page number
    typedef struct packed {
        logic              taken;
        logic [PAGE_W-1:0] page;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/swap_slot_table_unit.sv
// Swap slot table unit: maps virtual pages to swap slots.
// Depends on sst_pkg, sst_ram and swap_slot_table_unit_assert.svh.
//
// Usage:
//   in_valid/in_ready/in_data carry one request: opcode (store, load, free)
//   and page number. out_valid/out_ready/out_data return exactly one result
//   per request: status, slot index and first disk sector of the slot.
//   cfg_valid/cfg_ready/cfg_data write the slot count; cfg_ready is always
//   high. Write it only while no request is in flight.
// Scan:
//   Every request scans all table entries through the single read port of
//   the table RAM, one entry per cycle, then writes back at most one entry.
//   One request is in flight at a time; a new request is accepted only after
//   the result of the last one has been registered.
// Reset:
//   After reset the unit sweeps the table RAM and marks every slot free;
//   in_ready stays low during the sweep.
// Stall:
//   The result sits in an output register. A new request is accepted while
//   it waits; that request's result is held back until out_ready drains it.
`default_nettype none

module swap_slot_table_unit #(
    parameter int NUM_SLOTS        = 256,
    parameter int SECTORS_PER_SLOT = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire sst_pkg::in_t                in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output sst_pkg::out_t                    out_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [sst_pkg::COUNT_W-1:0] cfg_data
);

    localparam int AW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SW    = $clog2(SECTORS_PER_SLOT + 1);
    localparam int PW    = AW + SW;
    localparam int EW    = (PW > sst_pkg::SECTOR_W) ? PW : sst_pkg::SECTOR_W;
    localparam int IW    = (AW > sst_pkg::SLOT_W) ? AW : sst_pkg::SLOT_W;
    localparam int CMPW  = (AW > sst_pkg::COUNT_W) ? AW : sst_pkg::COUNT_W;
    localparam int ENT_W = $bits(sst_pkg::entry_t);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DECIDE
    } state_t;

    state_t                      state_reg,       state_next;
    logic [sst_pkg::COUNT_W-1:0] count_reg,       count_next;
    sst_pkg::in_t                req_reg,         req_next;
    logic [AW-1:0]               scan_addr_reg,   scan_addr_next;
    logic                        chk_valid_reg,   chk_valid_next;
    logic [AW-1:0]               chk_addr_reg,    chk_addr_next;
    logic                        free_found_reg,  free_found_next;
    logic [AW-1:0]               free_slot_reg,   free_slot_next;
    logic                        match_found_reg, match_found_next;
    logic [AW-1:0]               match_slot_reg,  match_slot_next;
    logic                        out_valid_reg,   out_valid_next;
    sst_pkg::out_t               out_data_reg,    out_data_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    sst_pkg::entry_t             ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [ENT_W-1:0]            ram_rdata;
    sst_pkg::entry_t             rd_entry;

    logic [sst_pkg::STATUS_W-1:0] res_status;
    logic [AW-1:0]                res_slot;
    logic [EW-1:0]                res_sector;
    logic [IW-1:0]                res_index;
    logic                         out_free;

    // Table memory: taken flag and page per slot
    sst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = sst_pkg::entry_t'(ram_rdata);
    assign out_free = !out_valid_reg || out_ready;

    // Result decode from the scan outcome
    always_comb
    begin
        res_status = sst_pkg::ST_ABSENT;
        res_slot   = '0;
        unique case (req_reg.opcode)
            sst_pkg::OP_STORE:
            begin
                if (!free_found_reg)
                begin
                    res_status = sst_pkg::ST_FULL;
                end
                else if (match_found_reg)
                begin
                    res_status = sst_pkg::ST_DUP;
                end
                else
                begin
                    res_status = sst_pkg::ST_OK;
                    res_slot   = free_slot_reg;
                end
            end
            sst_pkg::OP_LOAD, sst_pkg::OP_FREE:
            begin
                if (match_found_reg)
                begin
                    res_status = sst_pkg::ST_OK;
                    res_slot   = match_slot_reg;
                end
            end
            default:
            begin
                res_status = sst_pkg::ST_ABSENT;
            end
        endcase
        // Slot index and sector (res_slot is zero on error); cut to field widths at the output register
        res_index  = IW'(res_slot);
        res_sector = EW'(res_slot) * EW'(SECTORS_PER_SLOT);
    end

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        req_next         = req_reg;
        scan_addr_next   = scan_addr_reg;
        chk_valid_next   = 1'b0;
        chk_addr_next    = scan_addr_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        ram_we           = 1'b0;
        ram_waddr        = scan_addr_reg;
        ram_wdata        = '0;
        ram_raddr        = scan_addr_reg;

        // Config write
        if (cfg_valid)
        begin
            count_next = cfg_data;
        end

        // Output drain
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Check the entry read last cycle: first match anywhere, first free below count
        if (chk_valid_reg)
        begin
            if (rd_entry.taken && rd_entry.page == req_reg.page_number && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_slot_next  = chk_addr_reg;
            end
            if (!rd_entry.taken && !free_found_reg
                && CMPW'(chk_addr_reg) < CMPW'(count_reg))
            begin
                free_found_next = 1'b1;
                free_slot_next  = chk_addr_reg;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Mark every slot free, one per cycle
                ram_we = 1'b1;
                if (scan_addr_reg == LAST_ADDR)
                begin
                    scan_addr_next = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next         = in_data;
                    scan_addr_next   = '0;
                    free_found_next  = 1'b0;
                    match_found_next = 1'b0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Issue one read per cycle
                chk_valid_next = 1'b1;
                chk_addr_next  = scan_addr_reg;
                if (scan_addr_reg == LAST_ADDR)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                // Last read data is checked this cycle
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status       = res_status;
                    out_data_next.slot_index   = res_index[sst_pkg::SLOT_W-1:0];
                    out_data_next.first_sector = res_sector[sst_pkg::SECTOR_W-1:0];
                    // Write back: claim on store, release on load or free
                    if (res_status == sst_pkg::ST_OK)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = res_slot;
                        ram_wdata.taken = (req_reg.opcode == sst_pkg::OP_STORE);
                        ram_wdata.page  = req_reg.page_number;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            count_reg       <= sst_pkg::COUNT_RESET;
            req_reg         <= '0;
            scan_addr_reg   <= '0;
            chk_valid_reg   <= 1'b0;
            chk_addr_reg    <= '0;
            free_found_reg  <= 1'b0;
            free_slot_reg   <= '0;
            match_found_reg <= 1'b0;
            match_slot_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            req_reg         <= req_next;
            scan_addr_reg   <= scan_addr_next;
            chk_valid_reg   <= chk_valid_next;
            chk_addr_reg    <= chk_addr_next;
            free_found_reg  <= free_found_next;
            free_slot_reg   <= free_slot_next;
            match_found_reg <= match_found_next;
            match_slot_reg  <= match_slot_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `include "swap_slot_table_unit_assert.svh"

    `SST_ASSERT_SAME(a_no_write_idle, state_reg == S_IDLE, !ram_we, "table write while idle")
    `SST_ASSERT_SAME(a_error_zero_fields, out_valid_reg && out_data_reg.status != sst_pkg::ST_OK, out_data_reg.slot_index == '0 && out_data_reg.first_sector == '0, "error result with nonzero slot")
    `SST_ASSERT_NEXT(a_scan_starts_clean, in_valid && in_ready, state_reg == S_SCAN && scan_addr_reg == '0 && !free_found_reg && !match_found_reg, "scan did not start clean")
    `SST_ASSERT_SAME(a_writeback_flag, state_reg == S_DECIDE && ram_we, ram_wdata.taken == (req_reg.opcode == sst_pkg::OP_STORE), "write-back taken flag wrong")
    `SST_ASSERT_SAME(a_free_below_count, free_found_reg && state_reg != S_IDLE, CMPW'(free_slot_reg) < CMPW'(count_reg), "free slot beyond slot count")

endmodule

`default_nettype wire

// File: rtl/core/sst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 256
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
